// File: hw/rtl/ivs_pkg.sv
// Shared types and constants for the indexed value stack.
`timescale 1ns / 1ps
package ivs_pkg;

	localparam int OPCODE_W = 3;
	localparam int INDEX_W  = 10;
	localparam int SECOND_W = 8;
	localparam int NEED_W   = 9;
	localparam int TAG_W    = 4;
	localparam int PAY_W    = 64;
	localparam int DEPTH_W  = 9;
	localparam int STATUS_W = 2;
	localparam int VALUE_W  = TAG_W + PAY_W;

	typedef logic [OPCODE_W-1:0] opcode_t;
	typedef logic [STATUS_W-1:0] status_t;
	typedef logic [1:0] kind_t;

	localparam opcode_t OP_PUSH    = 3'd0;
	localparam opcode_t OP_POP     = 3'd1;
	localparam opcode_t OP_GET     = 3'd2;
	localparam opcode_t OP_SET     = 3'd3;
	localparam opcode_t OP_REVERSE = 3'd4;
	localparam opcode_t OP_CHECK   = 3'd5;

	localparam status_t ST_OK        = 2'd0;
	localparam status_t ST_OVERFLOW  = 2'd1;
	localparam status_t ST_UNDERFLOW = 2'd2;
	localparam status_t ST_BADINDEX  = 2'd3;

	// Work the back end has to do for one item.
	localparam kind_t K_NONE  = 2'd0;
	localparam kind_t K_READ  = 2'd1;
	localparam kind_t K_WRITE = 2'd2;
	localparam kind_t K_REV   = 2'd3;

	typedef struct packed {
		logic signed [INDEX_W-1:0] abs_index;
		logic                      valid;
		logic                      room;
		status_t                   status;
		logic [DEPTH_W-1:0]        depth;
	} res_t;

endpackage

// File: hw/rtl/ivs_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module ivs_ram #(
	parameter int WIDTH = 68,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// File: hw/rtl/ivs_queue.sv
// Two-entry command queue between the front and back ends.
`timescale 1ns / 1ps
module ivs_queue #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] din,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] dout,
	output logic             empty
);
	logic [WIDTH-1:0] entry_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;

	assign full  = (count_q == 2'd2);
	assign empty = (count_q == 2'd0);
	assign dout  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end
endmodule

// File: hw/rtl/ivs_front.sv
// Front end: keeps the stack depth, classifies each item and builds its command.
`timescale 1ns / 1ps
module ivs_front #(
	parameter int CAPACITY = 256
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                take,
	input  ivs_pkg::opcode_t                    opcode,
	input  logic signed [ivs_pkg::INDEX_W-1:0]  index,
	input  logic [ivs_pkg::SECOND_W-1:0]        second_index,
	input  logic [ivs_pkg::NEED_W-1:0]          needed_slots,
	output ivs_pkg::kind_t                      kind,
	output logic [$clog2(CAPACITY)-1:0]         addr_a,
	output logic [$clog2(CAPACITY)-1:0]         addr_b,
	output ivs_pkg::res_t                       res
);
	import ivs_pkg::*;

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int WW = ((CW > INDEX_W) ? CW : INDEX_W) + 2;

	logic [CW-1:0]        top_q;
	logic [CW-1:0]        top_n;
	logic [CW-1:0]        top_dec;
	logic signed [WW-1:0] top_s;
	logic signed [WW-1:0] idx_s;
	logic signed [WW-1:0] to_s;
	logic signed [WW-1:0] need_s;
	logic signed [WW-1:0] free_s;
	logic signed [WW-1:0] a_s;
	logic signed [WW-1:0] am1_s;
	logic                 ok;

	always_comb begin
		top_dec = top_q - CW'(1);
		top_s   = $signed(WW'(top_q));
		idx_s   = WW'(index);
		to_s    = $signed(WW'(second_index));
		need_s  = $signed(WW'(needed_slots));
		free_s  = $signed(WW'(CAPACITY)) - top_s;
		a_s     = (idx_s < 0) ? (idx_s + top_s + $signed(WW'(1))) : idx_s;
		am1_s   = a_s - $signed(WW'(1));
		ok      = (a_s > 0) && (a_s <= top_s);

		top_n         = top_q;
		kind          = K_NONE;
		addr_a        = '0;
		addr_b        = '0;
		res.abs_index = '0;
		res.valid     = 1'b0;
		res.room      = 1'b0;
		res.status    = ST_OK;

		case (opcode)
			OP_PUSH: begin
				if (top_q == CW'(CAPACITY)) begin
					res.status = ST_OVERFLOW;
				end else begin
					kind   = K_WRITE;
					addr_a = top_q[AW-1:0];
					top_n  = top_q + CW'(1);
				end
			end
			OP_POP: begin
				if (top_q == '0) begin
					res.status = ST_UNDERFLOW;
				end else begin
					kind   = K_READ;
					addr_a = top_dec[AW-1:0];
					top_n  = top_dec;
				end
			end
			OP_GET, OP_SET: begin
				res.abs_index = a_s[INDEX_W-1:0];
				res.valid     = ok;
				addr_a        = am1_s[AW-1:0];
				if (ok) begin
					kind = (opcode == OP_GET) ? K_READ : K_WRITE;
				end else if (opcode == OP_SET) begin
					res.status = ST_BADINDEX;
				end
			end
			OP_REVERSE: begin
				if (idx_s < to_s) begin
					if (idx_s < 0 || to_s >= top_s) begin
						res.status = ST_BADINDEX;
					end else begin
						kind   = K_REV;
						addr_a = idx_s[AW-1:0];
						addr_b = to_s[AW-1:0];
					end
				end
			end
			OP_CHECK: begin
				res.room = (free_s >= need_s);
			end
			default: begin
			end
		endcase

		res.depth = DEPTH_W'(top_n);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q <= '0;
		end else if (take) begin
			top_q <= top_n;
		end
	end
endmodule

// File: hw/rtl/ivs_back.sv
// Back end: carries out slot reads, writes and span reversals, and drives results.
`timescale 1ns / 1ps
module ivs_back #(
	parameter int CAPACITY = 256
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               q_empty,
	input  ivs_pkg::kind_t                     q_kind,
	input  logic [$clog2(CAPACITY)-1:0]        q_addr_a,
	input  logic [$clog2(CAPACITY)-1:0]        q_addr_b,
	input  logic [ivs_pkg::VALUE_W-1:0]        q_value,
	input  ivs_pkg::res_t                      q_res,
	output logic                               q_pop,
	output logic                               done,
	output logic [ivs_pkg::TAG_W-1:0]          out_tag,
	output logic signed [ivs_pkg::PAY_W-1:0]   out_payload,
	output ivs_pkg::res_t                      out_res
);
	import ivs_pkg::*;

	localparam int AW = $clog2(CAPACITY);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_READ = 3'd1;
	localparam logic [2:0] S_RVB  = 3'd2;
	localparam logic [2:0] S_RVWA = 3'd3;
	localparam logic [2:0] S_RVWB = 3'd4;

	logic [2:0]         state_q;
	logic               done_q;
	logic [AW-1:0]      lo_q;
	logic [AW-1:0]      hi_q;
	logic [VALUE_W-1:0] hold_q;
	res_t               res_q;
	logic [VALUE_W-1:0] value_out_q;
	res_t               res_out_q;

	logic               ram_we;
	logic [AW-1:0]      ram_waddr;
	logic [VALUE_W-1:0] ram_wdata;
	logic [AW-1:0]      ram_raddr;
	logic [VALUE_W-1:0] ram_rdata;
	logic               more_pairs;

	ivs_ram #(
		.WIDTH(VALUE_W),
		.DEPTH(CAPACITY)
	) u_slots (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign more_pairs = (({1'b0, lo_q} + (AW + 1)'(2)) < {1'b0, hi_q});

	always_comb begin
		q_pop     = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = lo_q;
		ram_wdata = ram_rdata;
		ram_raddr = lo_q;
		case (state_q)
			S_IDLE: begin
				if (!q_empty) begin
					q_pop     = 1'b1;
					ram_raddr = q_addr_a;
					ram_waddr = q_addr_a;
					ram_wdata = q_value;
					ram_we    = (q_kind == K_WRITE);
				end
			end
			S_RVB: begin
				ram_raddr = hi_q;
			end
			S_RVWA: begin
				ram_we    = 1'b1;
				ram_waddr = lo_q;
				ram_wdata = ram_rdata;
			end
			S_RVWB: begin
				ram_we    = 1'b1;
				ram_waddr = hi_q;
				ram_wdata = hold_q;
				ram_raddr = lo_q + AW'(1);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (!q_empty) begin
						if (q_kind == K_READ) begin
							state_q <= S_READ;
						end else if (q_kind == K_REV) begin
							state_q <= S_RVB;
						end else begin
							done_q <= 1'b1;
						end
					end
				end
				S_READ: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				S_RVB: begin
					state_q <= S_RVWA;
				end
				S_RVWA: begin
					state_q <= S_RVWB;
				end
				S_RVWB: begin
					if (more_pairs) begin
						state_q <= S_RVB;
					end else begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				lo_q        <= q_addr_a;
				hi_q        <= q_addr_b;
				res_q       <= q_res;
				value_out_q <= '0;
				res_out_q   <= q_res;
			end
			S_READ: begin
				value_out_q <= ram_rdata;
				res_out_q   <= res_q;
			end
			S_RVB: begin
				hold_q <= ram_rdata;
			end
			S_RVWB: begin
				lo_q        <= lo_q + AW'(1);
				hi_q        <= hi_q - AW'(1);
				value_out_q <= '0;
				res_out_q   <= res_q;
			end
			default: begin
			end
		endcase
	end

	assign done        = done_q;
	assign out_tag     = value_out_q[VALUE_W-1:PAY_W];
	assign out_payload = value_out_q[PAY_W-1:0];
	assign out_res     = res_out_q;
endmodule

// File: hw/rtl/indexed_value_stack_unit.sv
// Top level of the indexed value stack: front end, command queue and back end.
`timescale 1ns / 1ps
// An item is taken at a rising edge where start is high and busy is low. The
// front end classifies it at once, updates the depth and places a command in a
// two-entry queue; busy is high only while that queue is full. The back end
// owns the slot memory, which has one write and one registered read port.
// Each item yields one result, shown for one cycle with done high; the
// receiver cannot stall, so results leave as soon as they are formed.
// From acceptance, the command waits in the queue until the back end, when
// idle, pops it. Push, set, check, faults and reverse of an empty span then
// complete from the idle state; pop and get go on through S_READ for the
// memory read; reverse loops through S_RVB, S_RVWA and S_RVWB per pair, since every
// swapped pair needs two reads and two writes, overlapped on the read and
// write ports. Back-to-back pushes, sets and checks sustain one item per
// cycle; pops and gets visit S_READ before the next pop, so busy can rise.
// Reset clears the depth, the queue and the back-end state; slot contents are
// not cleared; only slots below the current depth are ever returned.
module indexed_value_stack_unit #(
	parameter int CAPACITY = 256
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  ivs_pkg::opcode_t                   opcode,
	input  logic signed [ivs_pkg::INDEX_W-1:0] index,
	input  logic [ivs_pkg::SECOND_W-1:0]       second_index,
	input  logic [ivs_pkg::NEED_W-1:0]         needed_slots,
	input  logic [ivs_pkg::TAG_W-1:0]          value_tag,
	input  logic signed [ivs_pkg::PAY_W-1:0]   value_payload,
	output logic                               done,
	output logic [ivs_pkg::TAG_W-1:0]          out_tag,
	output logic signed [ivs_pkg::PAY_W-1:0]   out_payload,
	output logic signed [ivs_pkg::INDEX_W-1:0] absolute_index,
	output logic                               index_valid,
	output logic                               room_ok,
	output ivs_pkg::status_t                   status,
	output logic [ivs_pkg::DEPTH_W-1:0]        depth
);
	import ivs_pkg::*;

	localparam int AW = $clog2(CAPACITY);
	localparam int QW = 2 + 2 * AW + VALUE_W + $bits(res_t);

	logic               take;
	logic               q_full;
	logic               q_empty;
	logic               q_pop;
	logic [QW-1:0]      q_din;
	logic [QW-1:0]      q_dout;
	kind_t              f_kind;
	logic [AW-1:0]      f_addr_a;
	logic [AW-1:0]      f_addr_b;
	res_t               f_res;
	kind_t              b_kind;
	logic [AW-1:0]      b_addr_a;
	logic [AW-1:0]      b_addr_b;
	logic [VALUE_W-1:0] b_value;
	res_t               b_res;
	res_t               out_res;

	assign busy = q_full;
	assign take = start && !q_full;

	ivs_front #(
		.CAPACITY(CAPACITY)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (take),
		.opcode      (opcode),
		.index       (index),
		.second_index(second_index),
		.needed_slots(needed_slots),
		.kind        (f_kind),
		.addr_a      (f_addr_a),
		.addr_b      (f_addr_b),
		.res         (f_res)
	);

	assign q_din = {f_kind, f_addr_a, f_addr_b, value_tag, value_payload, f_res};

	ivs_queue #(
		.WIDTH(QW)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (take),
		.din   (q_din),
		.full  (q_full),
		.pop   (q_pop),
		.dout  (q_dout),
		.empty (q_empty)
	);

	assign {b_kind, b_addr_a, b_addr_b, b_value, b_res} = q_dout;

	ivs_back #(
		.CAPACITY(CAPACITY)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.q_kind     (b_kind),
		.q_addr_a   (b_addr_a),
		.q_addr_b   (b_addr_b),
		.q_value    (b_value),
		.q_res      (b_res),
		.q_pop      (q_pop),
		.done       (done),
		.out_tag    (out_tag),
		.out_payload(out_payload),
		.out_res    (out_res)
	);

	assign absolute_index = out_res.abs_index;
	assign index_valid    = out_res.valid;
	assign room_ok        = out_res.room;
	assign status         = out_res.status;
	assign depth          = out_res.depth;
endmodule
